// ===== rtl/core/dpt_pkg.sv =====
// Shared types and constants for the deterministic primality test.
// Holds the controller state enum, the command/status bundles and the witness table.
// No dependencies.
package dpt_pkg;

  localparam int unsigned NUM_WITNESS = 3;
  localparam int unsigned WIT_BITS    = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_STRIP,
    ST_BASE,
    ST_SQ,
    ST_SQ_WAIT,
    ST_MB,
    ST_MB_WAIT,
    ST_NEXT_BIT,
    ST_EVAL,
    ST_R_CHECK,
    ST_R_WAIT,
    ST_R_TEST,
    ST_NEXT_K,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic strip;
    logic pow_init;
    logic mul_sq;
    logic mul_base;
    logic mul_run;
    logic bit_dec;
    logic r_init;
    logic r_inc;
    logic k_inc;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic le_one;
    logic tiny_prime;
    logic even;
    logic d_odd;
    logic mul_last;
    logic exp_bit;
    logic bit_last;
    logic x_one;
    logic x_nm1;
    logic r_done;
    logic k_last;
  } dp_status_t;

  // Miller-Rabin witnesses 2, 7, 61
  function automatic logic [WIT_BITS-1:0] witness(input logic [1:0] k);
    logic [WIT_BITS-1:0] w;
    case (k)
      2'd0:    w = 6'd2;
      2'd1:    w = 6'd7;
      default: w = 6'd61;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/dpt_ctrl.sv =====
// Controller state machine for the primality test.
// Sequences classification, Miller-Rabin powering and squaring rounds.
// Depends on dpt_pkg.
module dpt_ctrl
  import dpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t st_i
);

  state_e state_q, state_d;
  logic   res_q, res_d;

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (st_i.le_one) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else if (st_i.tiny_prime) begin
          res_d = 1'b1; state_d = ST_DONE;
        end else if (st_i.even) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else begin
          state_d = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (st_i.d_odd) begin
          state_d = ST_BASE;
        end else begin
          cmd_o.strip = 1'b1;
        end
      end
      ST_BASE: begin
        cmd_o.pow_init = 1'b1;
        state_d        = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        cmd_o.mul_run = 1'b1;
        if (st_i.mul_last) state_d = st_i.exp_bit ? ST_MB : ST_NEXT_BIT;
      end
      ST_MB: begin
        cmd_o.mul_base = 1'b1;
        state_d        = ST_MB_WAIT;
      end
      ST_MB_WAIT: begin
        cmd_o.mul_run = 1'b1;
        if (st_i.mul_last) state_d = ST_NEXT_BIT;
      end
      ST_NEXT_BIT: begin
        if (st_i.bit_last) begin
          state_d = ST_EVAL;
        end else begin
          cmd_o.bit_dec = 1'b1;
          state_d       = ST_SQ;
        end
      end
      ST_EVAL: begin
        if (st_i.x_one || st_i.x_nm1) begin
          state_d = ST_NEXT_K;
        end else begin
          cmd_o.r_init = 1'b1;
          state_d      = ST_R_CHECK;
        end
      end
      ST_R_CHECK: begin
        if (st_i.r_done) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else begin
          cmd_o.mul_sq = 1'b1;
          state_d      = ST_R_WAIT;
        end
      end
      ST_R_WAIT: begin
        cmd_o.mul_run = 1'b1;
        if (st_i.mul_last) state_d = ST_R_TEST;
      end
      ST_R_TEST: begin
        if (st_i.x_one) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else if (st_i.x_nm1) begin
          state_d = ST_NEXT_K;
        end else begin
          cmd_o.r_inc = 1'b1;
          state_d     = ST_R_CHECK;
        end
      end
      ST_NEXT_K: begin
        if (st_i.k_last) begin
          res_d = 1'b1; state_d = ST_DONE;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_BASE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign result_o    = res_q;

endmodule

// ===== rtl/core/dpt_dp.sv =====
// Datapath for the primality test: operand registers and a bit-serial modular multiplier.
// Driven by command bundles from dpt_ctrl; reports status flags back.
// Depends on dpt_pkg.
module dpt_dp
  import dpt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic [VALUE_BITS-1:0] candidate_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            st_o
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned IW = $clog2(W);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  n_q, nm1_q, d_q, x_q, acc_q, mb_q;
  logic [IW-1:0] s_q, r_q, bit_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    k_q;

  logic [W:0]   dbl, dbl_red, sum;
  logic [W-1:0] acc_d;

  // One multiplier bit: acc = 2*acc (+ x) mod n
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    sum     = dbl_red + (mb_q[W-1] ? {1'b0, x_q} : '0);
    acc_d   = (sum >= {1'b0, n_q}) ? W'(sum - {1'b0, n_q}) : sum[W-1:0];
  end

  // Operand and loop registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= candidate_i;
      nm1_q <= candidate_i - W'(1);
      d_q   <= candidate_i - W'(1);
      s_q   <= '0;
      k_q   <= '0;
    end
    if (cmd_i.strip) begin
      d_q <= d_q >> 1;
      s_q <= s_q + IW'(1);
    end
    if (cmd_i.pow_init) begin
      x_q   <= W'(1);
      bit_q <= IW'(W - 1);
    end
    if (cmd_i.bit_dec) bit_q <= bit_q - IW'(1);
    if (cmd_i.r_init)  r_q <= IW'(1);
    if (cmd_i.r_inc)   r_q <= r_q + IW'(1);
    if (cmd_i.k_inc)   k_q <= k_q + 2'd1;
    // Start a multiply: square, or multiply by the current witness
    if (cmd_i.mul_sq || cmd_i.mul_base) begin
      acc_q <= '0;
      mb_q  <= cmd_i.mul_sq ? x_q : {{(W-WIT_BITS){1'b0}}, witness(k_q)};
      cnt_q <= CW'(W);
    end
    if (cmd_i.mul_run) begin
      acc_q <= acc_d;
      mb_q  <= mb_q << 1;
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) x_q <= acc_d;
    end
  end

  // Status flags
  always_comb begin
    st_o.le_one     = (n_q <= W'(1));
    st_o.tiny_prime = (n_q == W'(2)) || (n_q == W'(3)) || (n_q == W'(7)) || (n_q == W'(61));
    st_o.even       = ~n_q[0];
    st_o.d_odd      = d_q[0];
    st_o.mul_last   = (cnt_q == CW'(1));
    st_o.exp_bit    = d_q[bit_q];
    st_o.bit_last   = (bit_q == '0);
    st_o.x_one      = (x_q == W'(1));
    st_o.x_nm1      = (x_q == nm1_q);
    st_o.r_done     = (r_q >= s_q);
    st_o.k_last     = (k_q == 2'(NUM_WITNESS - 1));
  end

endmodule

// ===== rtl/core/deterministic_primality_test.sv =====
// Channel  Dir  tdata bits (low first)   Notes
// s_axis   in   candidate[VALUE_BITS-1:0]  request taken when tvalid & tready
// m_axis   out  is_prime[0], zeros above   held until tready
//
// Top level of the 32-bit deterministic primality test (Miller-Rabin, witnesses 2, 7, 61).
// Depends on dpt_pkg, dpt_ctrl and dpt_dp.
// Trivial and even candidates are settled in classification; odd ones run Miller-Rabin
//   with up to s - 1 squaring rounds per witness on the shift-add modular multiplier,
//   one multiplier bit per cycle.
// One request at a time; s_axis_tready_o is high only while idle.
// Reset is asynchronous and returns the controller to idle; no clearing pass.
// A stalled result holds m_axis_tdata_o and the block takes no request until it is read.
module deterministic_primality_test
  import dpt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata_i,  // [VALUE_BITS-1:0] candidate
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o   // [0] is_prime
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       result;

  dpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  dpt_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .candidate_i (s_axis_tdata_i[VALUE_BITS-1:0]),
    .cmd_i       (cmd),
    .st_o        (st)
  );

  assign m_axis_tdata_o = {7'd0, result};

`ifndef ASSERT_OFF
  // Never accept a request while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("request accepted while result pending");

  // A result never appears in the cycle right after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o)
    else $error("result too early");

  // Multiplier runs only while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_run |-> (!s_axis_tready_o && !m_axis_tvalid_o))
    else $error("multiplier active outside busy phase");
`endif

endmodule
